// ----- src/utf8d_pkg.sv -----
package utf8d_pkg;

  // Widths of the word fields.
  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned LenW  = 3;

  // Sequence lengths, in bytes.
  localparam logic [LenW-1:0] LEN_ONE   = 3'd1;
  localparam logic [LenW-1:0] LEN_TWO   = 3'd2;
  localparam logic [LenW-1:0] LEN_THREE = 3'd3;
  localparam logic [LenW-1:0] LEN_FOUR  = 3'd4;

  // Continuation bytes still expected after each kind of lead byte.
  localparam logic [1:0] REM_NONE  = 2'd0;
  localparam logic [1:0] REM_ONE   = 2'd1;
  localparam logic [1:0] REM_TWO   = 2'd2;
  localparam logic [1:0] REM_THREE = 2'd3;

  // One decoded result word.
  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic [LenW-1:0]  seq_length;
    logic             bad_lead;
  } result_t;

endpackage

// ----- src/utf8d_core.sv -----
module utf8d_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [utf8d_pkg::ByteW-1:0]  byte_in,
  output logic                         has_result,
  output utf8d_pkg::result_t           result
);
  import utf8d_pkg::*;

  logic [CodeW-1:0] acc;
  logic [CodeW-1:0] acc_next;
  logic [1:0]       remaining;
  logic [1:0]       remaining_next;
  logic [LenW-1:0]  seq_len;
  logic [LenW-1:0]  seq_len_next;

  // Decode one byte against the open sequence, if any.
  always_comb begin
    acc_next       = acc;
    remaining_next = remaining;
    seq_len_next   = seq_len;
    has_result     = 1'b0;
    result         = '0;
    if (remaining != REM_NONE) begin
      // Continuation: shift in the low six bits, prefix is not checked.
      acc_next          = {acc[CodeW-7:0], byte_in[5:0]};
      remaining_next    = remaining - 2'd1;
      has_result        = (remaining == REM_ONE);
      result.code_point = acc_next;
      result.seq_length = seq_len;
      result.bad_lead   = 1'b0;
    end else if (!byte_in[7]) begin
      // Plain ASCII completes at once.
      has_result        = 1'b1;
      result.code_point = {{(CodeW-ByteW){1'b0}}, byte_in};
      result.seq_length = LEN_ONE;
    end else if (byte_in[7:4] == 4'hF) begin
      acc_next       = {{(CodeW-3){1'b0}}, byte_in[2:0]};
      remaining_next = REM_THREE;
      seq_len_next   = LEN_FOUR;
    end else if (byte_in[7:5] == 3'h7) begin
      acc_next       = {{(CodeW-4){1'b0}}, byte_in[3:0]};
      remaining_next = REM_TWO;
      seq_len_next   = LEN_THREE;
    end else if (byte_in[7:6] == 2'h3) begin
      acc_next       = {{(CodeW-5){1'b0}}, byte_in[4:0]};
      remaining_next = REM_ONE;
      seq_len_next   = LEN_TWO;
    end else begin
      // A continuation byte where a lead byte was expected.
      has_result        = 1'b1;
      result.code_point = '0;
      result.seq_length = LEN_ONE;
      result.bad_lead   = 1'b1;
    end
  end

  // Sequence state moves only when the byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      remaining <= REM_NONE;
      seq_len   <= '0;
    end else if (advance) begin
      acc       <= acc_next;
      remaining <= remaining_next;
      seq_len   <= seq_len_next;
    end
  end

endmodule

// ----- src/utf8_stream_decoder.sv -----
// UTF-8 stream decoder: takes one byte word per cycle while in_stall is low
// and gives one result word for each completed character.
// Input channel: in_valid, in_byte, in_stall. A byte is taken at a rising
// edge where in_valid is high and in_stall is low.
// Output channel: out_valid, code_point, seq_length, bad_lead, out_stall.
// A result is taken at an edge where out_valid is high and out_stall is low.
// Bytes inside a multi-byte sequence give no result; the byte that ends it
// gives the code point and the length. A continuation byte found where a
// lead byte belongs gives code point zero, length one and bad_lead set.
// A byte taken at one edge lands in the input register, is decoded there by
// the combinational core, and its result enters the output register once
// that register is free. Throughput is one byte per cycle while the output
// is not stalled, set by the single decode step between the two registers.
// When the receiver stalls, the output register holds its word; in_stall
// rises only once the input register also holds a waiting byte.
// Reset (synchronous, rst high) empties both registers and drops any
// partly decoded sequence, so the next byte is treated as a lead byte.
module utf8_stream_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [utf8d_pkg::ByteW-1:0]        in_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [utf8d_pkg::CodeW-1:0]        code_point,
  output logic [utf8d_pkg::LenW-1:0]         seq_length,
  output logic                               bad_lead
);
  import utf8d_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_reg;
  logic             out_free;
  logic             advance;
  logic             has_result;
  result_t          result;
  result_t          out_reg;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign advance  = byte_valid && out_free;
  assign in_stall = byte_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_reg <= in_byte;
    end
  end

  utf8d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .byte_in    (byte_reg),
    .has_result (has_result),
    .result     (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_reg <= result;
    end
  end

  assign code_point = out_reg.code_point;
  assign seq_length = out_reg.seq_length;
  assign bad_lead   = out_reg.bad_lead;

endmodule

// ----- test/tb_utf8_stream_decoder.sv -----
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int unsigned RandomBytes = 1700;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned ReportLimit = 50;

  // One planned input word, with an optional hand-written expected result.
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             typed;
    result_t          want;
  } stim_row_t;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic [ByteW-1:0] in_byte = '0;
  logic             in_stall;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CodeW-1:0] code_point;
  logic [LenW-1:0]  seq_length;
  logic             bad_lead;

  utf8_stream_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .seq_length (seq_length),
    .bad_lead   (bad_lead)
  );

  // Decoder state as the predictor sees it, starting from reset.
  logic [CodeW-1:0] acc_bits   = '0;
  logic [1:0]       bytes_left = REM_NONE;
  logic [LenW-1:0]  open_len   = '0;

  stim_row_t   byte_plan[$];
  result_t     pending_chars[$];
  stim_row_t   cur_row = '0;
  int unsigned bytes_taken = 0;
  int unsigned plan_total = 0;
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left = 0;
  int unsigned stall_phase = 0;

  // Directed words: extremes, stray continuations, each sequence length,
  // leads above 0xF7 and continuations with a wrong prefix.
  stim_row_t directed_rows [24] = '{
    '{8'h00, 1'b1, '{21'h0, LEN_ONE, 1'b0}},
    '{8'h7F, 1'b1, '{21'h7F, LEN_ONE, 1'b0}},
    '{8'h80, 1'b1, '{21'h0, LEN_ONE, 1'b1}},
    '{8'hBF, 1'b1, '{21'h0, LEN_ONE, 1'b1}},
    '{8'hC2, 1'b0, '0},
    '{8'hA9, 1'b0, '0},
    '{8'hDF, 1'b0, '0},
    '{8'hBF, 1'b1, '{21'h7FF, LEN_TWO, 1'b0}},
    '{8'hE2, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'hAC, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'h9F, 1'b0, '0},
    '{8'h98, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'hEF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b1, '{21'hFFFF, LEN_THREE, 1'b0}}
  };

  // Advance the predicted decoder by one byte and say whether a result comes out.
  function automatic void decode_byte(input logic [ByteW-1:0] b, output bit got,
                                      output result_t r);
    got = 1'b0;
    r = '0;
    if (bytes_left != REM_NONE) begin
      // Any byte here counts as a continuation; only its low six bits are kept.
      acc_bits = {acc_bits[CodeW-7:0], b[5:0]};
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == REM_NONE) begin
        got = 1'b1;
        r.code_point = acc_bits;
        r.seq_length = open_len;
      end
    end else if (!b[7]) begin
      got = 1'b1;
      r.code_point = CodeW'(b);
      r.seq_length = LEN_ONE;
    end else if (b[7:4] == 4'hF) begin
      acc_bits = CodeW'(b[2:0]);
      bytes_left = REM_THREE;
      open_len = LEN_FOUR;
    end else if (b[7:5] == 3'b111) begin
      acc_bits = CodeW'(b[3:0]);
      bytes_left = REM_TWO;
      open_len = LEN_THREE;
    end else if (b[7:6] == 2'b11) begin
      acc_bits = CodeW'(b[4:0]);
      bytes_left = REM_ONE;
      open_len = LEN_TWO;
    end else begin
      // A continuation byte where a lead byte belongs.
      got = 1'b1;
      r.seq_length = LEN_ONE;
      r.bad_lead = 1'b1;
    end
  endfunction

  function automatic void add_byte(input logic [ByteW-1:0] v);
    stim_row_t row;
    row = '0;
    row.value = v;
    byte_plan.push_back(row);
  endfunction

  // Mostly well-formed characters with random content, plus noise bytes and
  // sequences cut short so that the next lead is swallowed as a continuation.
  function automatic void build_random_plan();
    int unsigned      roll;
    int unsigned      n_cont;
    logic [ByteW-1:0] lead;
    int unsigned      count;
    count = 0;
    while (count < RandomBytes) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        add_byte(ByteW'($urandom_range(0, 255)));
        count++;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            lead = ByteW'($urandom_range(0, 127));
            n_cont = 0;
          end
          1: begin
            lead = ByteW'(8'hC0 | $urandom_range(0, 31));
            n_cont = 1;
          end
          2: begin
            lead = ByteW'(8'hE0 | $urandom_range(0, 15));
            n_cont = 2;
          end
          default: begin
            lead = ByteW'(8'hF0 | $urandom_range(0, 15));
            n_cont = 3;
          end
        endcase
        if (roll < 16 && n_cont > 0) begin
          n_cont = $urandom_range(0, n_cont - 1);
        end
        add_byte(lead);
        count++;
        repeat (n_cont) begin
          add_byte(ByteW'(8'h80 | $urandom_range(0, 63)));
          count++;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < ReportLimit) begin
      $display("tb: mismatch at %0t ns: %s", $time, msg);
    end
    errors++;
  endtask

  // Record an accepted byte word and queue the result it should produce.
  task automatic accept_byte(input stim_row_t row);
    bit      got;
    result_t r;
    decode_byte(row.value, got, r);
    bytes_taken++;
    if (row.typed) begin
      pending_chars.push_back(row.want);
    end else if (got) begin
      pending_chars.push_back(r);
    end
  endtask

  // Compare an accepted result word with the oldest expected one.
  task automatic check_char();
    result_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected word code_point=%h seq_length=%0d bad_lead=%b",
                                code_point, seq_length, bad_lead));
      return;
    end
    want = pending_chars.pop_front();
    if (code_point !== want.code_point) begin
      report_mismatch($sformatf("code_point %h, expected %h", code_point, want.code_point));
    end
    if (seq_length !== want.seq_length) begin
      report_mismatch($sformatf("seq_length %0d, expected %0d", seq_length, want.seq_length));
    end
    if (bad_lead !== want.bad_lead) begin
      report_mismatch($sformatf("bad_lead %b, expected %b", bad_lead, want.bad_lead));
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Input side: byte words go out in bursts of random length with random gaps, sometimes none, between.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accept_byte(cur_row);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || byte_plan.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_row = byte_plan.pop_front();
          in_valid <= 1'b1;
          in_byte <= cur_row.value;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Output side: check accepted words and stall in modes that change over time.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_char();
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
        stall_phase = 0;
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        StallNone:  out_stall <= 1'b0;
        StallLight: out_stall <= ($urandom_range(0, 9) < 3);
        StallHeavy: out_stall <= ($urandom_range(0, 9) < 8);
        default:    out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // Main sequence: build the plan, release reset, wait for every result.
  initial begin
    foreach (directed_rows[i]) byte_plan.push_back(directed_rows[i]);
    build_random_plan();
    plan_total = byte_plan.size();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (bytes_taken < plan_total) @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
